// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and constants of the moving average filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

  // Field and register widths
  localparam int SampleW = 16;
  localparam int SumW    = 24;
  localparam int WinW    = 9;
  localparam int DataW   = 32;
  localparam int AddrW   = 3;

  // Defaults
  localparam int            MAX_WINDOW_DEF = 256;
  localparam logic [WinW-1:0] WIN_RESET    = 9'd16;

  // Register word index (paddr[2])
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // Divider steps, one quotient bit per step
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_SETUP,
    ST_DIV,
    ST_CLEAR,
    ST_DONE
  } maf_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic accum;
    logic setup;
    logic div_step;
    logic clr_step;
    logic out_load;
  } maf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic clr_last;
    logic out_free;
  } maf_stat_t;

endpackage

`default_nettype wire

// File: rtl/maf_ctrl.sv
// ----------------------------------------------------------------------------
// maf_ctrl
// Sequencer: memory clear sweep, sample update, iterative divide, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module maf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              op_i,
  output logic                   in_stall_o,
  input  wire maf_pkg::maf_stat_t stat_i,
  output maf_pkg::maf_cmd_t      cmd_o,
  output maf_pkg::maf_state_e    state_o
);

  maf_pkg::maf_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= maf_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      maf_pkg::ST_INIT: begin
        if (stat_i.clr_last) state_d = maf_pkg::ST_IDLE;
      end
      maf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = op_i ? maf_pkg::ST_CLEAR : maf_pkg::ST_READ;
      end
      maf_pkg::ST_READ:  state_d = maf_pkg::ST_ACCUM;
      maf_pkg::ST_ACCUM: state_d = maf_pkg::ST_SETUP;
      maf_pkg::ST_SETUP: state_d = maf_pkg::ST_DIV;
      maf_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = maf_pkg::ST_DONE;
      end
      maf_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = maf_pkg::ST_DONE;
      end
      maf_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = maf_pkg::ST_IDLE;
      end
      default: state_d = maf_pkg::ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      maf_pkg::ST_INIT: cmd_o.clr_step = 1'b1;
      maf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      maf_pkg::ST_READ:  cmd_o.rd       = 1'b1;
      maf_pkg::ST_ACCUM: cmd_o.accum    = 1'b1;
      maf_pkg::ST_SETUP: cmd_o.setup    = 1'b1;
      maf_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      maf_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      maf_pkg::ST_DONE:  cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

// File: rtl/maf_dp.sv
// ----------------------------------------------------------------------------
// maf_dp
// Sample store, running sum, restoring divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module maf_dp #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire maf_pkg::maf_cmd_t           cmd_i,
  output maf_pkg::maf_stat_t               stat_o,
  input  wire logic [maf_pkg::WinW-1:0]    win_i,
  input  wire logic                        op_i,
  input  wire logic signed [maf_pkg::SampleW-1:0] sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [maf_pkg::SampleW-1:0] average_o
);

  localparam int IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LenW = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (LenW > maf_pkg::WinW) ? LenW : maf_pkg::WinW;
  localparam int SW   = maf_pkg::SampleW;
  localparam int UW   = maf_pkg::SumW;

  // Sample store
  logic [SW-1:0] mem_q [MAX_WINDOW];
  logic [SW-1:0] rd_q;
  logic          we;
  logic [IdxW-1:0] waddr;
  logic [SW-1:0] wdata;

  // Item registers
  logic            op_q;
  logic [SW-1:0]   sample_q;
  logic [LenW-1:0] len_q;
  logic [IdxW-1:0] idx_q;

  // Filter state
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [UW-1:0]   sum_q, sum_d;
  logic [IdxW-1:0] clr_cnt_q;

  // Divider
  logic [UW-1:0]   dq_q;
  logic [LenW-1:0] rem_q;
  logic            neg_q;
  logic [maf_pkg::DivCntW-1:0] cnt_q;

  // Output register
  logic          out_valid_q;
  logic [SW-1:0] out_avg_q;

  logic [LenW-1:0] len_c;
  logic [CW-1:0]   win_ext;
  logic [IdxW-1:0] idx_c;
  logic [CW-1:0]   nxt_idx;
  logic [LenW:0]   rem_sh;
  logic            q_bit;
  logic [LenW-1:0] rem_nxt;
  logic [UW-1:0]   sum_abs;
  logic [SW-1:0]   sat_c;
  logic [SW-1:0]   res_c;
  logic            clr_last;

  // Effective window length and start index
  always_comb begin
    win_ext = CW'(win_i);
    if (win_i == '0) begin
      len_c = LenW'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      len_c = LenW'(MAX_WINDOW);
    end else begin
      len_c = LenW'(win_i);
    end
    idx_c = (CW'(wr_idx_q) >= CW'(len_c)) ? '0 : wr_idx_q;
  end

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      sample_q <= sample_i;
      len_q    <= len_c;
      idx_q    <= idx_c;
    end
  end

  // Store write port: clear sweep or sample update
  assign clr_last = (clr_cnt_q == IdxW'(MAX_WINDOW - 1));

  always_comb begin
    we    = cmd_i.clr_step | cmd_i.accum;
    waddr = cmd_i.clr_step ? clr_cnt_q : idx_q;
    wdata = cmd_i.clr_step ? '0 : sample_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Running sum and write index update
  always_comb begin
    sum_d    = sum_q + {{(UW-SW){sample_q[SW-1]}}, sample_q}
                     - {{(UW-SW){rd_q[SW-1]}}, rd_q};
    nxt_idx  = CW'(idx_q) + CW'(1);
    wr_idx_d = (nxt_idx >= CW'(len_q)) ? '0 : IdxW'(nxt_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      wr_idx_q  <= '0;
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      sum_q     <= '0;
      wr_idx_q  <= '0;
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + IdxW'(1);
    end else if (cmd_i.accum) begin
      sum_q     <= sum_d;
      wr_idx_q  <= wr_idx_d;
    end
  end

  // Restoring divide of |sum| by the window length, one bit per step
  assign sum_abs = sum_q[UW-1] ? (~sum_q + UW'(1)) : sum_q;

  always_comb begin
    rem_sh  = {rem_q, dq_q[UW-1]};
    q_bit   = (rem_sh >= {1'b0, len_q});
    rem_nxt = q_bit ? LenW'(rem_sh - {1'b0, len_q}) : LenW'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      cnt_q <= maf_pkg::DivCntW'(maf_pkg::DivSteps);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - maf_pkg::DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      dq_q  <= sum_abs;
      rem_q <= '0;
      neg_q <= sum_q[UW-1];
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[UW-2:0], q_bit};
      rem_q <= rem_nxt;
    end
  end

  // Restore the sign and saturate to 16 bits; clear answers zero
  always_comb begin
    if (neg_q) begin
      sat_c = (dq_q > UW'(32768)) ? 16'h8000 : SW'(~dq_q[SW-1:0] + SW'(1));
    end else begin
      sat_c = (dq_q > UW'(32767)) ? 16'h7FFF : dq_q[SW-1:0];
    end
    res_c = op_q ? '0 : sat_c;
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_avg_q <= res_c;
    end
  end

  assign stat_o.div_last = (cnt_q == maf_pkg::DivCntW'(1));
  assign stat_o.clr_last = clr_last;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;

endmodule

`default_nettype wire

// File: rtl/moving_average_filter_top.sv
// ----------------------------------------------------------------------------
// moving_average_filter_top
// Moving average over the last window_length signed 16-bit samples.
// ----------------------------------------------------------------------------
// Each sample beat replaces the oldest stored sample, updates a 24-bit
// running sum and returns the sum divided by the effective window length
// (truncated toward zero, saturated to 16 bits). Between one accept and
// the next, when the result is taken at once, come a store read, the sum
// update, divider setup, 24 steps of a one-bit-per-cycle restoring
// divider, and the output load. A clear beat sweeps the whole sample
// store one entry per cycle and answers 0. After reset the same sweep
// runs before the first beat is accepted; configuration writes are taken
// at any time. Write window_length (offset 0x0) only while idle and
// follow it with a clear.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module moving_average_filter_top #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [maf_pkg::AddrW-1:0]          paddr,
  input  wire logic [maf_pkg::DataW-1:0]          pwdata,
  output logic [maf_pkg::DataW-1:0]               prdata,
  output logic                                    pready,
  // Input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               op_i,
  input  wire logic signed [maf_pkg::SampleW-1:0] sample_i,
  // Output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [maf_pkg::SampleW-1:0]      average_o
);

  logic [maf_pkg::WinW-1:0] win_q;
  logic                     cfg_wr;
  maf_pkg::maf_cmd_t        cmd;
  maf_pkg::maf_stat_t       stat;
  maf_pkg::maf_state_e      state;

  // Register write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == maf_pkg::REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= maf_pkg::WIN_RESET;
    end else if (cfg_wr) begin
      win_q <= pwdata[maf_pkg::WinW-1:0];
    end
  end

  // Register read
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      maf_pkg::REG_WINDOW_LENGTH: prdata = maf_pkg::DataW'(win_q);
      default: prdata = '0;
    endcase
  end

  maf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  maf_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .win_i       (win_q),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o)
  );

  // One beat in flight: an accepted beat closes the input until done
  `ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // No result while the store is swept after reset
  `ASSERT_IMP(a_init_quiet, clk_i, rst_ni, state == maf_pkg::ST_INIT, !out_valid_o)
  // A taken result leaves the output empty unless a new one loads
  `ASSERT_NXT(a_out_drain, clk_i, rst_ni,
              out_valid_o && !out_stall_i && (state != maf_pkg::ST_DONE), !out_valid_o)

endmodule

`default_nettype wire
